[sv/dq_pkg.sv]
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    // s side tdata: operation, push_value
    localparam int IN_OP_LSB    = 0;
    localparam int IN_VAL_LSB   = IN_OP_LSB + OP_W;
    localparam int IN_USED_W    = IN_VAL_LSB + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // m side tdata: popped_value, pop_failed, push_dropped, entry_count,
    // is_empty, front_value, back_value
    localparam int OUT_POP_LSB   = 0;
    localparam int OUT_FAIL_BIT  = OUT_POP_LSB + VALUE_W;
    localparam int OUT_DROP_BIT  = OUT_FAIL_BIT + 1;
    localparam int OUT_CNT_LSB   = OUT_DROP_BIT + 1;
    localparam int OUT_EMPTY_BIT = OUT_CNT_LSB + COUNT_W;
    localparam int OUT_FRONT_LSB = OUT_EMPTY_BIT + 1;
    localparam int OUT_BACK_LSB  = OUT_FRONT_LSB + VALUE_W;
    localparam int OUT_USED_W    = OUT_BACK_LSB + VALUE_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_NOP        = 3'd4
    } t_op;

endpackage

[sv/double_ended_queue.sv]
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed entries held in a ring memory.
// One operation (push front, push back, pop front, pop back, no change) is
// taken per cycle; its result sits in the output register in the cycle after
// the input transfer and the next operation is taken in that same cycle
// unless the output is stalled. Throughput is set by the front and back
// value caches: the two entries at each end live in registers and two
// prefetch read ports on the ring memory refill them, so every operation
// finishes in one pass. Pushes to a full queue are dropped and flagged,
// pops from an empty queue return -1 and are flagged. The ring needs no
// clearing after reset; stale values read from unoccupied slots go unused.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // operation [2:0], push_value [34:3]
    input  logic [dq_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // popped_value [31:0], pop_failed [32], push_dropped [33],
    // entry_count [44:34], is_empty [45], front_value [77:46],
    // back_value [109:78]
    output logic [dq_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : AW'(i + 1'b1);
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : AW'(i - 1'b1);
    endfunction

    function automatic logic [VALUE_W-1:0] f_ext(input logic [DATA_WIDTH-1:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[VALUE_W-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [AW-1:0]         r_front, n_front;
    logic [AW-1:0]         r_back,  n_back;
    logic [CW-1:0]         r_count, n_count;
    logic [DATA_WIDTH-1:0] r_f0, n_f0, r_f1, n_f1;
    logic [DATA_WIDTH-1:0] r_b0, n_b0, r_b1, n_b1;
    logic [DATA_WIDTH-1:0] r_pa, r_pb;
    logic                  r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    logic                  accept;
    t_op                   op;
    logic [DATA_WIDTH-1:0] val;
    logic                  we;
    logic [AW-1:0]         wa;
    logic [AW-1:0]         ra_a, ra_b;
    logic                  is_full, is_empty_now;
    logic                  pop_ok, fail, drop;
    logic [DATA_WIDTH-1:0] popped;
    logic [VALUE_W-1:0]    popped_out, front_out, back_out;

    assign o_s_tready   = i_rst_n && (!r_m_tvalid || i_m_tready);
    assign accept       = i_s_tvalid && o_s_tready;
    assign op           = t_op'(i_s_tdata[IN_OP_LSB +: OP_W]);
    assign val          = DATA_WIDTH'(i_s_tdata[IN_VAL_LSB +: VALUE_W]);
    assign is_full      = (r_count == CW'(DEPTH));
    assign is_empty_now = (r_count == '0);

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        n_f0    = r_f0;
        n_f1    = r_f1;
        n_b0    = r_b0;
        n_b1    = r_b1;
        we      = 1'b0;
        wa      = r_back;
        pop_ok  = 1'b0;
        fail    = 1'b0;
        drop    = 1'b0;
        popped  = r_f0;
        if (accept) begin
            case (op)
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        drop = 1'b1;
                    end else begin
                        n_front = f_prev(r_front);
                        we      = 1'b1;
                        wa      = n_front;
                        n_count = CW'(r_count + 1'b1);
                        n_f0    = val;
                        n_f1    = r_f0;
                        if (is_empty_now) begin
                            n_b0 = val;
                        end
                        if (r_count == CW'(1)) begin
                            n_b1 = val;
                        end
                    end
                end
                OP_PUSH_BACK: begin
                    if (is_full) begin
                        drop = 1'b1;
                    end else begin
                        n_back  = f_next(r_back);
                        we      = 1'b1;
                        wa      = r_back;
                        n_count = CW'(r_count + 1'b1);
                        n_b0    = val;
                        n_b1    = r_b0;
                        if (is_empty_now) begin
                            n_f0 = val;
                        end
                        if (r_count == CW'(1)) begin
                            n_f1 = val;
                        end
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty_now) begin
                        fail = 1'b1;
                    end else begin
                        pop_ok  = 1'b1;
                        popped  = r_f0;
                        n_front = f_next(r_front);
                        n_count = CW'(r_count - 1'b1);
                        n_f0    = r_f1;
                        n_f1    = r_pa;
                    end
                end
                OP_POP_BACK: begin
                    if (is_empty_now) begin
                        fail = 1'b1;
                    end else begin
                        pop_ok  = 1'b1;
                        popped  = r_b0;
                        n_back  = f_prev(r_back);
                        n_count = CW'(r_count - 1'b1);
                        n_b0    = r_b1;
                        n_b1    = r_pb;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // prefetch third entry from each end of the next state
    assign ra_a = f_next(f_next(n_front));
    assign ra_b = f_prev(f_prev(f_prev(n_back)));

    assign popped_out = pop_ok ? f_ext(popped) : '1;
    assign front_out  = (n_count == '0) ? '1 : f_ext(n_f0);
    assign back_out   = (n_count == '0) ? '1 : f_ext(n_b0);

    assign n_m_tdata = {
        (OUT_TDATA_W - OUT_USED_W)'(0),
        back_out,
        front_out,
        (n_count == '0),
        COUNT_W'(n_count),
        drop,
        fail,
        popped_out
    };

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= val;
        end
        r_pa <= (we && wa == ra_a) ? val : r_mem[ra_a];
        r_pb <= (we && wa == ra_b) ? val : r_mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_back     <= '0;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            if (accept) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f0 <= n_f0;
        r_f1 <= n_f1;
        r_b0 <= n_b0;
        r_b1 <= n_b1;
        if (accept) begin
            r_m_tdata <= n_m_tdata;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

[sv/dq_checker.sv]
`timescale 1ns / 1ps

module dq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [dq_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [dq_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import dq_pkg::*;

    logic                 fail, drop, empty;
    logic [COUNT_W-1:0]   count;
    logic [VALUE_W-1:0]   popped, front, back;
    logic                 in_seen;

    assign fail    = o_m_tdata[OUT_FAIL_BIT];
    assign drop    = o_m_tdata[OUT_DROP_BIT];
    assign empty   = o_m_tdata[OUT_EMPTY_BIT];
    assign count   = o_m_tdata[OUT_CNT_LSB +: COUNT_W];
    assign popped  = o_m_tdata[OUT_POP_LSB +: VALUE_W];
    assign front   = o_m_tdata[OUT_FRONT_LSB +: VALUE_W];
    assign back    = o_m_tdata[OUT_BACK_LSB +: VALUE_W];
    assign in_seen = i_s_tvalid && (i_s_tdata[IN_OP_LSB +: OP_W] != '1 || 1'b1);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_seen && o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("transfer taken while result stalled");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (empty == (count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && empty |-> (front == '1) && (back == '1))
        else $error("empty queue shows end values");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && fail |-> (popped == '1) && !drop)
        else $error("failed pop with value or drop");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
